FILE: rtl/tpi_pkg.sv
// Shared types and constants of the trapezoid position interpolator.
`timescale 1ns / 1ps
package tpi_pkg;

    localparam int DW  = 62;
    localparam int DVW = 17;
    localparam int RW  = 35;
    localparam int QW  = 31;

    localparam logic [2:0] PH_RAMP   = 3'd0;
    localparam logic [2:0] PH_CRUISE = 3'd1;
    localparam logic [2:0] PH_BRAKE  = 3'd2;
    localparam logic [2:0] PH_CRAWL  = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic [1:0] REG_CRUISE = 2'd0;
    localparam logic [1:0] REG_ACCEL  = 2'd1;
    localparam logic [1:0] REG_DECEL  = 2'd2;

    typedef struct packed {
        logic            start;
        logic            is_sqrt;
        logic            wide;
        logic [DW-1:0]   operand;
        logic [DVW-1:0]  divisor;
    } dsu_req_t;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [DW-1:0]   result;
    } dsu_rsp_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] speed;
    } appr_t;

    function automatic appr_t approach(logic [15:0] v, logic [15:0] goal, logic [14:0] step);
        logic [16:0] diff;
        logic [16:0] mag;
        appr_t       r;
        diff = {v[15], v} - {goal[15], goal};
        mag  = diff[16] ? 17'(-diff) : diff;
        if (mag <= {2'b00, step}) begin
            r.hit   = 1'b1;
            r.speed = goal;
        end else begin
            r.hit   = 1'b0;
            r.speed = diff[16] ? 16'(v + {1'b0, step}) : 16'(v - {1'b0, step});
        end
        return r;
    endfunction

endpackage

FILE: rtl/tpi_divsqrt.sv
// Iterative radix-2 divider and digit-by-digit square root sharing one subtractor.
`timescale 1ns / 1ps
module tpi_divsqrt (
    input  logic             aclk,
    input  logic             aresetn,
    input  tpi_pkg::dsu_req_t req,
    output tpi_pkg::dsu_rsp_t rsp
);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic                      sq_reg, sq_next;
    logic [tpi_pkg::DW-1:0]    sh_reg, sh_next;
    logic [tpi_pkg::RW-1:0]    rem_reg, rem_next;
    logic [tpi_pkg::QW-1:0]    root_reg, root_next;
    logic [tpi_pkg::DVW-1:0]   dv_reg, dv_next;
    logic [5:0]                cnt_reg, cnt_next;

    logic [tpi_pkg::RW-1:0]    xin, yin;
    logic [tpi_pkg::RW:0]      diff;
    logic                      ge;

    always_comb begin
        if (sq_reg) begin
            xin = {rem_reg[tpi_pkg::RW-3:0], sh_reg[tpi_pkg::DW-1:tpi_pkg::DW-2]};
            yin = {2'b00, root_reg, 2'b01};
        end else begin
            xin = {{(tpi_pkg::RW-tpi_pkg::DVW-1){1'b0}}, rem_reg[tpi_pkg::DVW-1:0],
                   sh_reg[tpi_pkg::DW-1]};
            yin = {{(tpi_pkg::RW-tpi_pkg::DVW){1'b0}}, dv_reg};
        end
        diff = {1'b0, xin} - {1'b0, yin};
        ge   = ~diff[tpi_pkg::RW];
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sq_next   = sq_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        dv_next   = dv_reg;
        cnt_next  = cnt_reg;
        if (busy_reg) begin
            rem_next = ge ? diff[tpi_pkg::RW-1:0] : xin;
            if (sq_reg) begin
                sh_next   = {sh_reg[tpi_pkg::DW-3:0], 2'b00};
                root_next = {root_reg[tpi_pkg::QW-2:0], ge};
            end else begin
                sh_next = {sh_reg[tpi_pkg::DW-2:0], ge};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            sq_next   = req.is_sqrt;
            dv_next   = req.divisor;
            rem_next  = '0;
            root_next = '0;
            if (req.is_sqrt || req.wide) begin
                sh_next = req.operand;
            end else begin
                sh_next = {req.operand[tpi_pkg::QW-1:0], {(tpi_pkg::DW-tpi_pkg::QW){1'b0}}};
            end
            cnt_next = (req.wide && !req.is_sqrt) ? 6'(tpi_pkg::DW) : 6'(tpi_pkg::QW);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        sq_reg   <= sq_next;
        sh_reg   <= sh_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        dv_reg   <= dv_next;
    end

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = sq_reg ? {{(tpi_pkg::DW-tpi_pkg::QW){1'b0}}, root_reg} : sh_reg;

endmodule

FILE: rtl/trapezoid_position_interpolator.sv
// Top level: move planner sequencer, tick stepper and result register.
//
// Input channel s_*: one beat is a start (s_kind = 1, with s_target_position) or a
// motion tick (s_kind = 0). Result channel m_*: exactly one beat per input beat,
// carrying position, signed speed, stage and the sticky done flag.
// Configuration channel cfg_*: cfg_index selects cruise speed (0), accel step (1)
// or decel step (2); a zero write is taken as one; write only while idle.
// One item is taken at a time. A tick steps through TICK1, TICK2 and OUT, and the
// next item is accepted only once the FSM is back in IDLE.
// A start runs three 31-step divisions on the shared divide/square-root unit;
// a short move adds a multiply, a 62-step division and a 31-step square root.
// The iteration count of that unit sets the start latency.
// Reset clears position, speed and plan, puts the stage at done and loads
// cruise 1000, accel 10, decel 10.
// A result waits in the output register while m_ready is low; the next item
// is accepted meanwhile, and its result is held back until the register frees.
`timescale 1ns / 1ps
module trapezoid_position_interpolator #(
    parameter int SETTLE_TICKS = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [30:0] s_target_position,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [30:0] m_position,
    output logic [15:0] m_speed,
    output logic [2:0]  m_stage,
    output logic        m_done_res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_wdata
);

    localparam int SW = (SETTLE_TICKS > 1) ? $clog2(SETTLE_TICKS + 1) : 1;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_PLAN   = 4'd1;
    localparam logic [3:0] ST_WAIT   = 4'd2;
    localparam logic [3:0] ST_DECIDE = 4'd3;
    localparam logic [3:0] ST_MUL    = 4'd4;
    localparam logic [3:0] ST_QISSUE = 4'd5;
    localparam logic [3:0] ST_COMMIT = 4'd6;
    localparam logic [3:0] ST_TICK1  = 4'd7;
    localparam logic [3:0] ST_TICK2  = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;

    localparam logic [2:0] OP_TX   = 3'd0;
    localparam logic [2:0] OP_TXA  = 3'd1;
    localparam logic [2:0] OP_SX   = 3'd2;
    localparam logic [2:0] OP_Q    = 3'd3;
    localparam logic [2:0] OP_SQRT = 3'd4;

    logic [3:0]  state_reg;
    logic [2:0]  op_reg;
    logic [14:0] cs_reg, acc_reg, dec_reg;
    logic [30:0] tgt_reg;
    logic [31:0] pos_reg, end_reg;
    logic [15:0] spd_reg, plan_reg, crawl_reg;
    logic [29:0] brake_reg;
    logic [2:0]  phase_reg;
    logic        hc_reg;
    logic [SW-1:0] settle_reg;
    logic        fin_reg;
    logic [32:0] vct_reg;
    logic [29:0] ad_reg, tx_reg, txa_reg, dist_reg;
    logic [30:0] sx_reg;
    logic [59:0] prod_reg;
    logic [15:0] mag_reg;
    logic        neg_reg;
    logic        m_valid_reg;
    logic [30:0] m_position_reg;
    logic [15:0] m_speed_reg;
    logic [2:0]  m_stage_reg;
    logic        m_done_reg;

    tpi_pkg::dsu_req_t du_req;
    tpi_pkg::dsu_rsp_t du_rsp;

    tpi_divsqrt u_divsqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (du_req),
        .rsp     (du_rsp)
    );

    logic        issue;
    logic [2:0]  issue_op;
    logic [14:0] cfg_val;

    assign cfg_val = (cfg_wdata == 15'd0) ? 15'd1 : cfg_wdata;

    always_comb begin
        issue    = 1'b0;
        issue_op = OP_TX;
        unique case (state_reg)
            ST_PLAN: begin
                issue = 1'b1;
            end
            ST_WAIT: begin
                if (du_rsp.done) begin
                    unique case (op_reg)
                        OP_TX:   begin issue = 1'b1; issue_op = OP_TXA;  end
                        OP_TXA:  begin issue = 1'b1; issue_op = OP_SX;   end
                        OP_Q:    begin issue = 1'b1; issue_op = OP_SQRT; end
                        default: begin issue = 1'b0; end
                    endcase
                end
            end
            ST_QISSUE: begin
                issue    = 1'b1;
                issue_op = OP_Q;
            end
            default: begin
                issue = 1'b0;
            end
        endcase
    end

    always_comb begin
        du_req.start   = issue;
        du_req.is_sqrt = 1'b0;
        du_req.wide    = 1'b0;
        du_req.operand = '0;
        du_req.divisor = '0;
        unique case (issue_op)
            OP_TX: begin
                du_req.operand = 62'(cs_reg * cs_reg);
                du_req.divisor = {1'b0, dec_reg, 1'b0};
            end
            OP_TXA: begin
                du_req.operand = 62'(cs_reg * cs_reg);
                du_req.divisor = {1'b0, acc_reg, 1'b0};
            end
            OP_SX: begin
                du_req.operand = 62'($signed(spd_reg) * $signed(spd_reg));
                du_req.divisor = {1'b0, dec_reg, 1'b0};
            end
            OP_Q: begin
                du_req.wide    = 1'b1;
                du_req.operand = {1'b0, prod_reg, 1'b0};
                du_req.divisor = {2'b00, acc_reg} + {2'b00, dec_reg};
            end
            OP_SQRT: begin
                du_req.is_sqrt = 1'b1;
                du_req.operand = du_rsp.result;
            end
            default: begin
                du_req.start = 1'b0;
            end
        endcase
    end

    // move planning
    logic [32:0] len_c, sx_ext;
    logic        vneg, vzero, vctz, along, rev_c, vct_pos;
    logic [34:0] dist_c;
    logic [30:0] span_c;
    logic        dneg, dgt, deq;

    always_comb begin
        len_c   = vct_reg[32] ? 33'(-vct_reg) : vct_reg;
        sx_ext  = {2'b00, sx_reg};
        vneg    = spd_reg[15];
        vzero   = (spd_reg == 16'd0);
        vctz    = (vct_reg == 33'd0);
        vct_pos = !vct_reg[32] && !vctz;
        along   = (!vct_reg[32] && !vneg) || ((vct_reg[32] || vctz) && (vneg || vzero));
        rev_c   = 1'b0;
        if (along) begin
            if (sx_ext > len_c) begin
                dist_c = {2'b00, sx_ext - len_c};
                rev_c  = 1'b1;
            end else if (sx_ext < len_c) begin
                dist_c = {2'b00, len_c};
            end else begin
                dist_c = '1;
            end
        end else begin
            dist_c = {2'b00, sx_ext} + {2'b00, len_c};
        end
        span_c = {1'b0, tx_reg} + {1'b0, txa_reg};
        dneg   = dist_c[34];
        dgt    = dist_c > {4'b0000, span_c};
        deq    = dist_c == {4'b0000, span_c};
    end

    // tick stepping
    tpi_pkg::appr_t ramp_c, brk_c;
    logic [32:0] pd_c, pda_c;
    logic [31:0] pos1_c;
    logic [32:0] rd_c, rda_c;
    logic [16:0] smag_c;
    logic        snap_c;

    always_comb begin
        ramp_c = tpi_pkg::approach(spd_reg, plan_reg, acc_reg);
        brk_c  = tpi_pkg::approach(spd_reg, crawl_reg, dec_reg);
        pd_c   = {pos_reg[31], pos_reg} - {end_reg[31], end_reg};
        pda_c  = pd_c[32] ? 33'(-pd_c) : pd_c;
        pos1_c = (phase_reg == tpi_pkg::PH_CRAWL && settle_reg >= SW'(SETTLE_TICKS))
               ? end_reg : pos_reg;
        rd_c   = {end_reg[31], end_reg} - {pos1_c[31], pos1_c};
        rda_c  = rd_c[32] ? 33'(-rd_c) : rd_c;
        smag_c = spd_reg[15] ? 17'(-{spd_reg[15], spd_reg}) : {1'b0, spd_reg};
        snap_c = rda_c <= {16'd0, smag_c};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_TX;
            cs_reg      <= 15'd1000;
            acc_reg     <= 15'd10;
            dec_reg     <= 15'd10;
            pos_reg     <= '0;
            end_reg     <= '0;
            spd_reg     <= '0;
            plan_reg    <= '0;
            crawl_reg   <= '0;
            brake_reg   <= '0;
            phase_reg   <= tpi_pkg::PH_DONE;
            hc_reg      <= 1'b0;
            settle_reg  <= '0;
            fin_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    tpi_pkg::REG_CRUISE: cs_reg  <= cfg_val;
                    tpi_pkg::REG_ACCEL:  acc_reg <= cfg_val;
                    tpi_pkg::REG_DECEL:  dec_reg <= cfg_val;
                    default: begin end
                endcase
            end
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (issue) begin
                op_reg <= issue_op;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        tgt_reg   <= s_target_position;
                        state_reg <= s_kind ? ST_PLAN : ST_TICK1;
                    end
                end
                ST_PLAN: begin
                    vct_reg   <= {{2{tgt_reg[30]}}, tgt_reg} - {pos_reg[31], pos_reg};
                    ad_reg    <= acc_reg * dec_reg;
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (du_rsp.done) begin
                        unique case (op_reg)
                            OP_TX:   tx_reg  <= du_rsp.result[29:0];
                            OP_TXA:  txa_reg <= du_rsp.result[29:0];
                            OP_SX: begin
                                sx_reg    <= du_rsp.result[30:0];
                                state_reg <= ST_DECIDE;
                            end
                            OP_SQRT: begin
                                mag_reg   <= du_rsp.result[15:0];
                                state_reg <= ST_COMMIT;
                            end
                            default: begin end
                        endcase
                    end
                end
                ST_DECIDE: begin
                    neg_reg  <= rev_c ? vct_pos : vct_reg[32];
                    mag_reg  <= {1'b0, cs_reg};
                    dist_reg <= dist_c[29:0];
                    hc_reg   <= !dneg && dgt;
                    if (!dneg && !dgt && !deq) begin
                        state_reg <= ST_MUL;
                    end else begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= ad_reg * dist_reg;
                    state_reg <= ST_QISSUE;
                end
                ST_QISSUE: begin
                    state_reg <= ST_WAIT;
                end
                ST_COMMIT: begin
                    plan_reg <= neg_reg ? 16'(-mag_reg) : mag_reg;
                    if (!neg_reg && mag_reg != 16'd0) begin
                        crawl_reg <= {1'b0, acc_reg};
                    end else begin
                        crawl_reg <= 16'(-{1'b0, acc_reg});
                    end
                    brake_reg  <= tx_reg;
                    end_reg    <= {tgt_reg[30], tgt_reg};
                    phase_reg  <= tpi_pkg::PH_RAMP;
                    settle_reg <= '0;
                    fin_reg    <= 1'b0;
                    state_reg  <= ST_OUT;
                end
                ST_TICK1: begin
                    unique case (phase_reg)
                        tpi_pkg::PH_RAMP: begin
                            settle_reg <= '0;
                            spd_reg    <= ramp_c.speed;
                            if (ramp_c.hit) begin
                                phase_reg <= hc_reg ? tpi_pkg::PH_CRUISE : tpi_pkg::PH_BRAKE;
                            end
                        end
                        tpi_pkg::PH_CRUISE: begin
                            if (pda_c <= {3'b000, brake_reg}) begin
                                phase_reg <= tpi_pkg::PH_BRAKE;
                            end
                        end
                        tpi_pkg::PH_BRAKE: begin
                            spd_reg <= brk_c.speed;
                            if (brk_c.hit) begin
                                phase_reg <= tpi_pkg::PH_CRAWL;
                            end
                        end
                        default: begin end
                    endcase
                    state_reg <= ST_TICK2;
                end
                ST_TICK2: begin
                    if (phase_reg == tpi_pkg::PH_CRAWL && settle_reg < SW'(SETTLE_TICKS)) begin
                        settle_reg <= settle_reg + SW'(1);
                    end
                    if (snap_c) begin
                        pos_reg   <= end_reg;
                        spd_reg   <= '0;
                        phase_reg <= tpi_pkg::PH_DONE;
                        fin_reg   <= 1'b1;
                    end else begin
                        pos_reg <= pos1_c + {{16{spd_reg[15]}}, spd_reg};
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_position_reg <= pos_reg[30:0];
            m_speed_reg    <= spd_reg;
            m_stage_reg    <= phase_reg;
            m_done_reg     <= fin_reg;
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign m_valid    = m_valid_reg;
    assign m_position = m_position_reg;
    assign m_speed    = m_speed_reg;
    assign m_stage    = m_stage_reg;
    assign m_done_res = m_done_reg;

    a_idle_unit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !du_rsp.busy)
        else $error("shared unit busy while idle");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        du_rsp.done |-> state_reg == ST_WAIT)
        else $error("unit result outside wait state");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= tpi_pkg::PH_DONE)
        else $error("stage out of range");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second beat taken while working");

    a_finished_done: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_reg |-> phase_reg == tpi_pkg::PH_DONE)
        else $error("done flag outside done stage");

endmodule
